// ===== hdl/smdc_pkg.sv =====
// Shared types, codes and default parameter values for the status/menu display controller.
// Used by every module of the block; depends on nothing.
`default_nettype none

package smdc_pkg;

    // Default tuning values, handed down from the top level.
    localparam int STATUS_REFRESH_TICKS_DEF = 50;
    localparam int MENU_TIMEOUT_TICKS_DEF   = 200;
    localparam int AUTO_SHOW_COOLDOWN_DEF   = 50;
    localparam int HALF_REFRESH_EVERY_DEF   = 24;
    localparam int RESYNC_EVERY_DEF         = 6;
    localparam int MENU_ITEMS_DEF           = 5;

    // Fixed field widths.
    localparam int COUNT_W    = 16;
    localparam int PAGE_W     = 2;
    localparam int CURSOR_W   = 3;
    localparam int KIND_W     = 2;
    localparam int ACTION_W   = 3;
    localparam int COOLDOWN_W = 6;

    // The cooldown counter saturates at its all-ones value.
    localparam logic [COOLDOWN_W-1:0] COOLDOWN_MAX = '1;

    // Status pages.
    localparam logic [PAGE_W-1:0] PAGE_OVERVIEW = 2'd0;
    localparam logic [PAGE_W-1:0] PAGE_CLIENTS  = 2'd1;
    localparam logic [PAGE_W-1:0] PAGE_SYSTEM   = 2'd2;

    // Refresh kinds.
    localparam logic [KIND_W-1:0] REFRESH_FAST = 2'd0;
    localparam logic [KIND_W-1:0] REFRESH_HALF = 2'd1;
    localparam logic [KIND_W-1:0] REFRESH_FULL = 2'd2;

    // Menu action codes.
    localparam logic [ACTION_W-1:0] ACT_NONE    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_TOGGLE0 = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REBOOT  = 3'd5;
    // Items below this index map to a toggle action.
    localparam logic [CURSOR_W-1:0] TOGGLE_ITEMS = 3'd4;

    // Register map of the configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_AUTO_SHOW = 3'd0;

    // One tick request.
    typedef struct packed {
        logic               btn_back;
        logic               btn_up;
        logic               btn_down;
        logic               btn_confirm;
        logic               btn_left;
        logic               btn_right;
        logic [COUNT_W-1:0] client_count;
        logic               uplink_up;
    } t_smdc_in;

    // One result per tick.
    typedef struct packed {
        logic                mode_menu;
        logic [PAGE_W-1:0]   page;
        logic [CURSOR_W-1:0] cursor;
        logic                redraw;
        logic [KIND_W-1:0]   refresh_kind;
        logic [ACTION_W-1:0] menu_action;
        logic                resync_request;
    } t_smdc_out;

endpackage

`default_nettype wire

// ===== hdl/smdc_cfg.sv =====
// APB-style configuration register file: holds the auto-show enable bit.
// Depends on smdc_pkg for the register map.
`default_nettype none

module smdc_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [smdc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [smdc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [smdc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output logic                                  o_auto_show_enable
);
    import smdc_pkg::*;

    logic r_auto_show_enable;
    logic wr_en;

    // The port never inserts wait states.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_AUTO_SHOW);

    // Auto-show enable register, on after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_show_enable <= 1'b1;
        end else if (wr_en) begin
            r_auto_show_enable <= pwdata[0];
        end
    end

    // Read data; unmapped addresses read as zero.
    always_comb begin
        prdata = '0;
        if (paddr == ADDR_AUTO_SHOW) begin
            prdata[0] = r_auto_show_enable;
        end
    end

    assign o_auto_show_enable = r_auto_show_enable;

endmodule

`default_nettype wire

// ===== hdl/smdc_core.sv =====
// Controller state and its next-state logic: page, menu, timers, auto-show and refresh kind.
// Depends on smdc_pkg for the request and result types and the codes.
`default_nettype none

module smdc_core #(
    parameter int STATUS_REFRESH_TICKS = smdc_pkg::STATUS_REFRESH_TICKS_DEF,
    parameter int MENU_TIMEOUT_TICKS   = smdc_pkg::MENU_TIMEOUT_TICKS_DEF,
    parameter int AUTO_SHOW_COOLDOWN   = smdc_pkg::AUTO_SHOW_COOLDOWN_DEF,
    parameter int HALF_REFRESH_EVERY   = smdc_pkg::HALF_REFRESH_EVERY_DEF,
    parameter int RESYNC_EVERY         = smdc_pkg::RESYNC_EVERY_DEF,
    parameter int MENU_ITEMS           = smdc_pkg::MENU_ITEMS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire smdc_pkg::t_smdc_in   i_req,
    input  wire logic                 i_auto_show_enable,
    output smdc_pkg::t_smdc_out       o_resp
);
    import smdc_pkg::*;

    // Counter widths: each holds its limit, the value at which it clears.
    localparam int TICK_W = $clog2(STATUS_REFRESH_TICKS + 1);
    localparam int IDLE_W = $clog2(MENU_TIMEOUT_TICKS + 1);
    localparam int RSYN_W = $clog2(RESYNC_EVERY + 1);
    localparam int RFSH_W = $clog2(HALF_REFRESH_EVERY + 1);

    localparam logic [TICK_W-1:0]     TICK_LIM  = TICK_W'(STATUS_REFRESH_TICKS);
    localparam logic [IDLE_W-1:0]     IDLE_LIM  = IDLE_W'(MENU_TIMEOUT_TICKS);
    localparam logic [RSYN_W-1:0]     RSYN_LIM  = RSYN_W'(RESYNC_EVERY);
    localparam logic [RFSH_W-1:0]     RFSH_LIM  = RFSH_W'(HALF_REFRESH_EVERY);
    localparam logic [COOLDOWN_W-1:0] COOL_LIM  = COOLDOWN_W'(AUTO_SHOW_COOLDOWN);
    localparam logic [CURSOR_W-1:0]   LAST_ITEM = CURSOR_W'(MENU_ITEMS - 1);

    // State registers and their next values.
    logic                  r_in_menu,   n_in_menu;
    logic [PAGE_W-1:0]     r_page,      n_page;
    logic [CURSOR_W-1:0]   r_cursor,    n_cursor;
    logic [TICK_W-1:0]     r_tick,      n_tick;
    logic [IDLE_W-1:0]     r_idle,      n_idle;
    logic [RSYN_W-1:0]     r_resync,    n_resync;
    logic [RFSH_W-1:0]     r_refresh,   n_refresh;
    logic [COOLDOWN_W-1:0] r_since,     n_since;
    logic [COUNT_W-1:0]    r_last_cnt,  n_last_cnt;
    logic                  r_last_up,   n_last_up;
    logic                  r_first,     n_first;

    // Working values of one tick.
    logic                  any_btn;
    logic                  redraw;
    logic [KIND_W-1:0]     kind;
    logic [ACTION_W-1:0]   action;
    logic                  resync;
    logic [COUNT_W-1:0]    last_cnt;
    logic                  last_up;
    logic [TICK_W-1:0]     tick_inc;
    logic [IDLE_W-1:0]     idle_inc;
    logic [RSYN_W-1:0]     rsyn_inc;
    logic [RFSH_W-1:0]     rfsh_inc;
    logic [COOLDOWN_W-1:0] since_inc;
    logic [CURSOR_W-1:0]   cur;
    logic                  jump;
    logic [PAGE_W-1:0]     target;

    always_comb begin
        n_in_menu  = r_in_menu;
        n_page     = r_page;
        n_cursor   = r_cursor;
        n_tick     = r_tick;
        n_idle     = r_idle;
        n_resync   = r_resync;
        n_refresh  = r_refresh;
        n_since    = r_since;
        n_first    = r_first;
        redraw     = 1'b0;
        kind       = REFRESH_FAST;
        action     = ACT_NONE;
        resync     = 1'b0;
        jump       = 1'b0;
        target     = PAGE_OVERVIEW;
        cur        = r_cursor;

        any_btn = i_req.btn_back || i_req.btn_up || i_req.btn_down ||
                  i_req.btn_confirm || i_req.btn_left || i_req.btn_right;

        // On the first tick the remembered values come from this request.
        last_cnt   = r_first ? i_req.client_count : r_last_cnt;
        last_up    = r_first ? i_req.uplink_up : r_last_up;
        n_last_cnt = last_cnt;
        n_last_up  = last_up;

        tick_inc  = TICK_W'(r_tick + 1'b1);
        idle_inc  = IDLE_W'(r_idle + 1'b1);
        rsyn_inc  = RSYN_W'(r_resync + 1'b1);
        rfsh_inc  = RFSH_W'(r_refresh + 1'b1);
        since_inc = (r_since < COOLDOWN_MAX) ? COOLDOWN_W'(r_since + 1'b1) : r_since;

        if (!r_in_menu) begin
            // Status mode: confirm opens the menu, left/right flip pages.
            if (i_req.btn_confirm) begin
                n_in_menu = 1'b1;
                n_cursor  = '0;
                n_idle    = '0;
                redraw    = 1'b1;
            end else if (i_req.btn_left || i_req.btn_right) begin
                // Both together cancel out.
                if (i_req.btn_right && !i_req.btn_left) begin
                    n_page = (r_page == PAGE_SYSTEM) ? PAGE_OVERVIEW : PAGE_W'(r_page + 1'b1);
                end else if (i_req.btn_left && !i_req.btn_right) begin
                    n_page = (r_page == PAGE_OVERVIEW) ? PAGE_SYSTEM : PAGE_W'(r_page - 1'b1);
                end
                n_tick = '0;
                redraw = 1'b1;
            end else if (tick_inc >= TICK_LIM) begin
                // Periodic redraw, with a resync request every few of them.
                n_tick = '0;
                redraw = 1'b1;
                if (rsyn_inc >= RSYN_LIM) begin
                    resync   = 1'b1;
                    n_resync = '0;
                end else begin
                    n_resync = rsyn_inc;
                end
            end else begin
                n_tick = tick_inc;
            end

            // Auto-show: an uplink change beats a client count change.
            if (i_auto_show_enable) begin
                n_since    = since_inc;
                n_last_cnt = i_req.client_count;
                n_last_up  = i_req.uplink_up;
                if (i_req.uplink_up != last_up) begin
                    jump   = 1'b1;
                    target = PAGE_OVERVIEW;
                end else if (i_req.client_count != last_cnt) begin
                    jump   = 1'b1;
                    target = PAGE_CLIENTS;
                end
                if ((since_inc >= COOL_LIM) && jump && (target != n_page)) begin
                    n_page  = target;
                    n_tick  = '0;
                    redraw  = 1'b1;
                    n_since = '0;
                end
            end
        end else begin
            // Menu mode.
            if (any_btn) begin
                n_idle = '0;
                redraw = 1'b1;
                if (i_req.btn_back) begin
                    n_in_menu = 1'b0;
                    n_tick    = '0;
                end else begin
                    if (i_req.btn_up) begin
                        cur = (cur == '0) ? LAST_ITEM : CURSOR_W'(cur - 1'b1);
                    end
                    if (i_req.btn_down) begin
                        cur = (cur == LAST_ITEM) ? '0 : CURSOR_W'(cur + 1'b1);
                    end
                    n_cursor = cur;
                    if (i_req.btn_confirm) begin
                        if (cur == LAST_ITEM) begin
                            action = ACT_REBOOT;
                        end else if (cur < TOGGLE_ITEMS) begin
                            action = ACTION_W'(ACT_TOGGLE0 + cur);
                        end
                    end
                end
            end else begin
                // Idle timeout closes the menu.
                n_idle = idle_inc;
                if (idle_inc >= IDLE_LIM) begin
                    n_in_menu = 1'b0;
                    n_tick    = '0;
                    redraw    = 1'b1;
                end
            end
        end

        // Refresh kind: full on the first tick, half every few redraws.
        if (r_first) begin
            redraw  = 1'b1;
            kind    = REFRESH_FULL;
            n_first = 1'b0;
        end else if (redraw) begin
            if (rfsh_inc >= RFSH_LIM) begin
                kind      = REFRESH_HALF;
                n_refresh = '0;
            end else begin
                n_refresh = rfsh_inc;
            end
        end

        o_resp.mode_menu      = n_in_menu;
        o_resp.page           = n_page;
        o_resp.cursor         = n_cursor;
        o_resp.redraw         = redraw;
        o_resp.refresh_kind   = kind;
        o_resp.menu_action    = action;
        o_resp.resync_request = resync;
    end

    // State update, once per request that moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_menu <= 1'b0;
            r_page    <= PAGE_OVERVIEW;
            r_cursor  <= '0;
            r_tick    <= '0;
            r_idle    <= '0;
            r_resync  <= '0;
            r_refresh <= '0;
            r_since   <= COOL_LIM;
            r_first   <= 1'b1;
        end else if (i_step) begin
            r_in_menu <= n_in_menu;
            r_page    <= n_page;
            r_cursor  <= n_cursor;
            r_tick    <= n_tick;
            r_idle    <= n_idle;
            r_resync  <= n_resync;
            r_refresh <= n_refresh;
            r_since   <= n_since;
            r_first   <= n_first;
        end
    end

    // Remembered count and uplink; valid once the first tick has passed.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_last_cnt <= n_last_cnt;
            r_last_up  <= n_last_up;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/status_menu_display_controller_top.sv =====
// Top level of the status/menu display controller: request and result registers around the core.
// Depends on smdc_pkg, smdc_cfg and smdc_core.
`default_nettype none

// Takes one request per UI tick and returns exactly one result per request. A request
// may be accepted in every clock cycle; each result appears once its request has passed
// the input register and the single next-state logic pass of the core into the result
// register. The input side stalls only while a result waits in the result register and
// the one behind it is already in the input register.
// The auto-show enable sits at configuration address 0 and should be written only while
// no request is in flight.
module status_menu_display_controller_top #(
    parameter int STATUS_REFRESH_TICKS = smdc_pkg::STATUS_REFRESH_TICKS_DEF,
    parameter int MENU_TIMEOUT_TICKS   = smdc_pkg::MENU_TIMEOUT_TICKS_DEF,
    parameter int AUTO_SHOW_COOLDOWN   = smdc_pkg::AUTO_SHOW_COOLDOWN_DEF,
    parameter int HALF_REFRESH_EVERY   = smdc_pkg::HALF_REFRESH_EVERY_DEF,
    parameter int RESYNC_EVERY         = smdc_pkg::RESYNC_EVERY_DEF,
    parameter int MENU_ITEMS           = smdc_pkg::MENU_ITEMS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire smdc_pkg::t_smdc_in               i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output smdc_pkg::t_smdc_out                   o_out_data,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [smdc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [smdc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [smdc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready
);
    import smdc_pkg::*;

    logic      r_in_valid;
    t_smdc_in  r_in_data;
    logic      r_out_valid;
    t_smdc_out r_out_data;
    t_smdc_out core_resp;
    logic      auto_show_enable;
    logic      out_free;
    logic      step;

    // Handshake: the result register frees when empty or when its result is taken.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // Configuration registers.
    smdc_cfg u_cfg (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .o_auto_show_enable (auto_show_enable)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_data <= i_in_data;
        end
    end

    // Controller state and next-state logic.
    smdc_core #(
        .STATUS_REFRESH_TICKS (STATUS_REFRESH_TICKS),
        .MENU_TIMEOUT_TICKS   (MENU_TIMEOUT_TICKS),
        .AUTO_SHOW_COOLDOWN   (AUTO_SHOW_COOLDOWN),
        .HALF_REFRESH_EVERY   (HALF_REFRESH_EVERY),
        .RESYNC_EVERY         (RESYNC_EVERY),
        .MENU_ITEMS           (MENU_ITEMS)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (step),
        .i_req              (r_in_data),
        .i_auto_show_enable (auto_show_enable),
        .o_resp             (core_resp)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= core_resp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire
